// ===== src/qer_pkg.sv =====
// ---------------------------------------------------------------------------
// Quadratic evaluator package
// Shared widths, register indexes, stage counts, sideband types and clipping.
// ---------------------------------------------------------------------------
package qer_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 2'd2;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned NUM_W      = 34;
  localparam int unsigned FRONT_LAT  = 4;
  // front + root steps + numerator + divider (input, steps, sign) + output
  localparam int unsigned PIPE_LAT   = FRONT_LAT + SQRT_STEPS + 1 + (DIV_STEPS + 2) + 1;

  typedef struct packed {
    logic signed [31:0] poly;
    logic               psat;
    logic               dneg;
    logic               deg;
    logic signed [15:0] a;
    logic signed [31:0] nb;
  } root_side_t;

  typedef struct packed {
    logic signed [31:0] poly;
    logic               psat;
    logic               dneg;
    logic               deg;
  } div_side_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clip_t;

  function automatic clip_t clip48(input logic signed [47:0] v);
    clip_t res;
    if (v > 48'sh0000_7FFF_FFFF) begin
      res.sat = 1'b1;
      res.val = 32'h7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      res.sat = 1'b1;
      res.val = 32'h8000_0000;
    end else begin
      res.sat = 1'b0;
      res.val = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== src/quadratic_eval_and_roots.sv =====
// ---------------------------------------------------------------------------
// Quadratic evaluator and root solver
// Evaluates a*x*x+b*x+c at each request and returns both roots of the
// polynomial, all as saturated Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration: write coef_a/b/c (signed Q8.8) through cfg_we_i,
//   cfg_idx_i and cfg_data_i while no request is in flight. Indexes past
//   coef_c are dropped. Reset loads a = 1.0, b = 0, c = 0.
//   Requests: a request is taken at each clock edge with start_i high and
//   busy_o low. busy_o is always low: the pipeline takes one request every
//   cycle, back to back.
//   Results: each request returns one result, marked by a one-cycle
//   result_valid_o pulse, in request order. The receiver cannot hold
//   results off, so none is ever stalled.
//   Pipeline: 4 front stages (products, discriminant, sum, clip), 32 stages
//   of integer square root (one root bit per stage), one numerator stage,
//   35 divider stages (one quotient bit per stage plus sign handling) and
//   one output register. The root and the divider set the depth.
//   Reset clears every valid bit, so nothing in flight survives it.
// ---------------------------------------------------------------------------
module quadratic_eval_and_roots (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [15:0]             x_value_i,
  output logic                           result_valid_o,
  output logic signed [31:0]             poly_value_o,
  output logic signed [31:0]             root_one_re_o,
  output logic signed [31:0]             root_one_im_o,
  output logic signed [31:0]             root_two_re_o,
  output logic signed [31:0]             root_two_im_o,
  output logic                           roots_complex_o,
  output logic                           degenerate_o,
  output logic                           saturated_o
);

  // Coefficient registers
  logic signed [15:0] coef_a_q, coef_b_q, coef_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= 16'sd256;
      coef_b_q <= 16'sd0;
      coef_c_q <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qer_pkg::REG_COEF_A: coef_a_q <= cfg_data_i;
        qer_pkg::REG_COEF_B: coef_b_q <= cfg_data_i;
        qer_pkg::REG_COEF_C: coef_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Fully pipelined: never refuse a request
  assign busy_o = 1'b0;

  // Front end: polynomial and discriminant
  logic                fr_vld;
  logic [63:0]         fr_v;
  qer_pkg::root_side_t fr_side;

  qer_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .x_i    (x_value_i),
    .a_i    (coef_a_q),
    .b_i    (coef_b_q),
    .c_i    (coef_c_q),
    .vld_o  (fr_vld),
    .v_o    (fr_v),
    .side_o (fr_side)
  );

  // Square root of |d| scaled by 2^30
  logic                sq_vld;
  logic [31:0]         sq_s;
  qer_pkg::root_side_t sq_side;

  qer_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fr_vld),
    .v_i    (fr_v),
    .side_i (fr_side),
    .vld_o  (sq_vld),
    .s_o    (sq_s),
    .side_o (sq_side)
  );

  // Numerator stage: real roots need -b*2^15 +/- s, complex ones -b*2^15 and s
  logic                                 nm_vld_q;
  logic signed [qer_pkg::NUM_W-1:0]     n1_q, n2_q;
  logic signed [15:0]                   den_q;
  qer_pkg::div_side_t                   nm_side_q;
  logic signed [qer_pkg::NUM_W-1:0]     nb_ext, s_ext;

  assign nb_ext = qer_pkg::NUM_W'(sq_side.nb);
  assign s_ext  = $signed({{(qer_pkg::NUM_W-32){1'b0}}, sq_s});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q <= 1'b0;
    end else begin
      nm_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q           <= sq_side.dneg ? nb_ext : nb_ext + s_ext;
    n2_q           <= sq_side.dneg ? s_ext  : nb_ext - s_ext;
    den_q          <= sq_side.a;
    nm_side_q.poly <= sq_side.poly;
    nm_side_q.psat <= sq_side.psat;
    nm_side_q.dneg <= sq_side.dneg;
    nm_side_q.deg  <= sq_side.deg;
  end

  // Divide both numerators by a
  logic                              dv_vld;
  logic signed [qer_pkg::NUM_W-1:0]  dv_q1, dv_q2;
  qer_pkg::div_side_t                dv_side;

  qer_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (nm_vld_q),
    .n1_i   (n1_q),
    .n2_i   (n2_q),
    .den_i  (den_q),
    .side_i (nm_side_q),
    .vld_o  (dv_vld),
    .q1_o   (dv_q1),
    .q2_o   (dv_q2),
    .side_o (dv_side)
  );

  // Output stage: clip, pick the root form, merge saturation
  qer_pkg::clip_t cl1, cl2, cl2n;

  assign cl1  = qer_pkg::clip48(48'(dv_q1));
  assign cl2  = qer_pkg::clip48(48'(dv_q2));
  assign cl2n = qer_pkg::clip48(-48'(dv_q2));

  logic               out_vld_q;
  logic signed [31:0] poly_q, r1re_q, r1im_q, r2re_q, r2im_q;
  logic               cplx_q, deg_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    poly_q <= dv_side.poly;
    deg_q  <= dv_side.deg;
    if (dv_side.deg) begin
      r1re_q <= '0;
      r1im_q <= '0;
      r2re_q <= '0;
      r2im_q <= '0;
      cplx_q <= 1'b0;
      sat_q  <= dv_side.psat;
    end else if (dv_side.dneg) begin
      r1re_q <= cl1.val;
      r2re_q <= cl1.val;
      r1im_q <= cl2.val;
      r2im_q <= cl2n.val;
      cplx_q <= 1'b1;
      sat_q  <= dv_side.psat | cl1.sat | cl2.sat | cl2n.sat;
    end else begin
      r1re_q <= cl1.val;
      r2re_q <= cl2.val;
      r1im_q <= '0;
      r2im_q <= '0;
      cplx_q <= 1'b0;
      sat_q  <= dv_side.psat | cl1.sat | cl2.sat;
    end
  end

  assign result_valid_o  = out_vld_q;
  assign poly_value_o    = poly_q;
  assign root_one_re_o   = r1re_q;
  assign root_one_im_o   = r1im_q;
  assign root_two_re_o   = r2re_q;
  assign root_two_im_o   = r2im_q;
  assign roots_complex_o = cplx_q;
  assign degenerate_o    = deg_q;
  assign saturated_o     = sat_q;

endmodule

// ===== src/qer_front.sv =====
// ---------------------------------------------------------------------------
// Quadratic evaluator front end
// Four stages: products, discriminant, polynomial sum, truncation and clip.
// ---------------------------------------------------------------------------
module qer_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic signed [15:0]   x_i,
  input  logic signed [15:0]   a_i,
  input  logic signed [15:0]   b_i,
  input  logic signed [15:0]   c_i,
  output logic                 vld_o,
  output logic [63:0]          v_o,
  output qer_pkg::root_side_t  side_o
);

  logic [qer_pkg::FRONT_LAT-1:0] vld_q;

  // stage 1
  logic signed [31:0] xx_q, bx_q, bb_q, ac_q, nb1_q;
  logic signed [15:0] a1_q, c1_q;
  // stage 2
  logic signed [47:0] axx_q;
  logic signed [34:0] d_q;
  logic signed [31:0] bx2_q, nb2_q;
  logic signed [15:0] a2_q, c2_q;
  // stage 3
  logic signed [47:0] acc_q;
  logic [33:0]        mag_q;
  logic               dneg3_q;
  logic signed [31:0] nb3_q;
  logic signed [15:0] a3_q;
  // stage 4
  logic [63:0]        v_q;
  qer_pkg::root_side_t side_q;

  logic signed [47:0] acc_d;
  logic signed [47:0] trunc_d;
  qer_pkg::clip_t     pclip_d;

  assign acc_d   = axx_q + (48'(bx2_q) <<< 8) + (48'(c2_q) <<< 16);
  assign trunc_d = (acc_q + (acc_q[47] ? 48'sd255 : 48'sd0)) >>> 8;
  assign pclip_d = qer_pkg::clip48(trunc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[qer_pkg::FRONT_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q  <= 32'(x_i * x_i);
    bx_q  <= 32'(b_i * x_i);
    bb_q  <= 32'(b_i * b_i);
    ac_q  <= 32'(a_i * c_i);
    nb1_q <= -(32'(b_i) <<< 15);
    a1_q  <= a_i;
    c1_q  <= c_i;

    axx_q <= 48'(a1_q) * 48'(xx_q);
    d_q   <= 35'(bb_q) - (35'(ac_q) <<< 2);
    bx2_q <= bx_q;
    nb2_q <= nb1_q;
    a2_q  <= a1_q;
    c2_q  <= c1_q;

    acc_q   <= acc_d;
    mag_q   <= d_q[34] ? 34'(-d_q) : 34'(d_q);
    dneg3_q <= d_q[34];
    nb3_q   <= nb2_q;
    a3_q    <= a2_q;

    v_q         <= 64'(mag_q) << 30;
    side_q.poly <= pclip_d.val;
    side_q.psat <= pclip_d.sat;
    side_q.dneg <= dneg3_q;
    side_q.deg  <= (a3_q == 16'sd0);
    side_q.a    <= a3_q;
    side_q.nb   <= nb3_q;
  end

  assign vld_o  = vld_q[qer_pkg::FRONT_LAT-1];
  assign v_o    = v_q;
  assign side_o = side_q;

endmodule

// ===== src/qer_sqrt.sv =====
// ---------------------------------------------------------------------------
// Quadratic evaluator square root
// Integer root of a 64-bit value, one result bit per stage.
// ---------------------------------------------------------------------------
module qer_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [63:0]          v_i,
  input  qer_pkg::root_side_t  side_i,
  output logic                 vld_o,
  output logic [31:0]          s_o,
  output qer_pkg::root_side_t  side_o
);

  localparam int unsigned N = qer_pkg::SQRT_STEPS;

  logic [N-1:0]        vld_q;
  logic [63:0]         v_q    [N];
  logic [63:0]         r_q    [N];
  qer_pkg::root_side_t side_q [N];

  logic [63:0]         v_d    [N];
  logic [63:0]         r_d    [N];
  qer_pkg::root_side_t side_d [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [63:0] vin, rin, bitv, sum;
      vin  = (k == 0) ? v_i : v_q[(k == 0) ? 0 : k-1];
      rin  = (k == 0) ? 64'd0 : r_q[(k == 0) ? 0 : k-1];
      bitv = 64'd1 << (62 - 2*k);
      sum  = rin + bitv;
      side_d[k] = (k == 0) ? side_i : side_q[(k == 0) ? 0 : k-1];
      if (vin >= sum) begin
        v_d[k] = vin - sum;
        r_d[k] = (rin >> 1) + bitv;
      end else begin
        v_d[k] = vin;
        r_d[k] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      v_q[k]    <= v_d[k];
      r_q[k]    <= r_d[k];
      side_q[k] <= side_d[k];
    end
  end

  assign vld_o  = vld_q[N-1];
  assign s_o    = r_q[N-1][31:0];
  assign side_o = side_q[N-1];

endmodule

// ===== src/qer_div.sv =====
// ---------------------------------------------------------------------------
// Quadratic evaluator divider
// Two signed quotients over one divisor, restoring, one bit per stage,
// truncating toward zero.
// ---------------------------------------------------------------------------
module qer_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vld_i,
  input  logic signed [qer_pkg::NUM_W-1:0]     n1_i,
  input  logic signed [qer_pkg::NUM_W-1:0]     n2_i,
  input  logic signed [15:0]                   den_i,
  input  qer_pkg::div_side_t                   side_i,
  output logic                                 vld_o,
  output logic signed [qer_pkg::NUM_W-1:0]     q1_o,
  output logic signed [qer_pkg::NUM_W-1:0]     q2_o,
  output qer_pkg::div_side_t                   side_o
);

  localparam int unsigned N  = qer_pkg::DIV_STEPS;
  localparam int unsigned MW = qer_pkg::NUM_W - 1;

  // index 0 is the input register, N the last step
  logic [N+1:0]          vld_q;
  logic [MW-1:0]         num1_q [N+1];
  logic [MW-1:0]         num2_q [N+1];
  logic [15:0]           rem1_q [N+1];
  logic [15:0]           rem2_q [N+1];
  logic [MW-1:0]         quo1_q [N+1];
  logic [MW-1:0]         quo2_q [N+1];
  logic [15:0]           den_q  [N+1];
  logic                  neg1_q [N+1];
  logic                  neg2_q [N+1];
  qer_pkg::div_side_t    side_q [N+1];

  logic [15:0]           rem1_d [N];
  logic [15:0]           rem2_d [N];
  logic                  bit1_d [N];
  logic                  bit2_d [N];

  logic signed [qer_pkg::NUM_W-1:0] q1_q, q2_q;
  qer_pkg::div_side_t               sideo_q;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [16:0] t1, t2;
      t1 = {rem1_q[k], num1_q[k][MW-1]};
      t2 = {rem2_q[k], num2_q[k][MW-1]};
      bit1_d[k] = (t1 >= {1'b0, den_q[k]});
      bit2_d[k] = (t2 >= {1'b0, den_q[k]});
      rem1_d[k] = bit1_d[k] ? 16'(t1 - {1'b0, den_q[k]}) : t1[15:0];
      rem2_d[k] = bit2_d[k] ? 16'(t2 - {1'b0, den_q[k]}) : t2[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    num1_q[0] <= n1_i[MW] ? MW'(-n1_i) : MW'(n1_i);
    num2_q[0] <= n2_i[MW] ? MW'(-n2_i) : MW'(n2_i);
    rem1_q[0] <= '0;
    rem2_q[0] <= '0;
    quo1_q[0] <= '0;
    quo2_q[0] <= '0;
    den_q[0]  <= den_i[15] ? 16'(-den_i) : 16'(den_i);
    neg1_q[0] <= n1_i[MW] ^ den_i[15];
    neg2_q[0] <= n2_i[MW] ^ den_i[15];
    side_q[0] <= side_i;
    for (int k = 0; k < N; k++) begin
      num1_q[k+1] <= num1_q[k] << 1;
      num2_q[k+1] <= num2_q[k] << 1;
      rem1_q[k+1] <= rem1_d[k];
      rem2_q[k+1] <= rem2_d[k];
      quo1_q[k+1] <= {quo1_q[k][MW-2:0], bit1_d[k]};
      quo2_q[k+1] <= {quo2_q[k][MW-2:0], bit2_d[k]};
      den_q[k+1]  <= den_q[k];
      neg1_q[k+1] <= neg1_q[k];
      neg2_q[k+1] <= neg2_q[k];
      side_q[k+1] <= side_q[k];
    end
    q1_q    <= neg1_q[N] ? -$signed({1'b0, quo1_q[N]}) : $signed({1'b0, quo1_q[N]});
    q2_q    <= neg2_q[N] ? -$signed({1'b0, quo2_q[N]}) : $signed({1'b0, quo2_q[N]});
    sideo_q <= side_q[N];
  end

  assign vld_o  = vld_q[N+1];
  assign q1_o   = q1_q;
  assign q2_o   = q2_q;
  assign side_o = sideo_q;

endmodule

// ===== src/qer_checker.sv =====
// ---------------------------------------------------------------------------
// Quadratic evaluator port checker
// Watches the top-level ports and flags broken request/result behaviour.
// ---------------------------------------------------------------------------
module qer_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [qer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [15:0]                    cfg_data_i,
  input logic                           start_i,
  input logic                           busy_o,
  input logic signed [15:0]             x_value_i,
  input logic                           result_valid_o,
  input logic signed [31:0]             poly_value_o,
  input logic signed [31:0]             root_one_re_o,
  input logic signed [31:0]             root_one_im_o,
  input logic signed [31:0]             root_two_re_o,
  input logic signed [31:0]             root_two_im_o,
  input logic                           roots_complex_o,
  input logic                           degenerate_o,
  input logic                           saturated_o
);

  // Every result answers a request taken exactly one latency earlier
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, qer_pkg::PIPE_LAT))
    else $error("result without matching request");

  // A request taken while running comes out after the latency
  a_request_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(qer_pkg::PIPE_LAT) (result_valid_o || !rst_ni))
    else $error("request lost");

  // Degenerate results carry zero, real roots
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |-> (!roots_complex_o && root_one_re_o == 32'sd0 &&
      root_two_re_o == 32'sd0 && root_one_im_o == 32'sd0 && root_two_im_o == 32'sd0))
    else $error("degenerate result with non-zero roots");

  // Complex pairs share the real part
  a_conjugate_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && roots_complex_o) |-> (root_one_re_o == root_two_re_o))
    else $error("complex roots not conjugate");

endmodule

bind quadratic_eval_and_roots qer_checker u_qer_checker (.*);
